[design/pol_pkg.sv]
`timescale 1ns / 1ps
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 5;
  // wide enough for position and count compares without wrap
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [2:0] F_APPEND    = 3'd0;
  localparam logic [2:0] F_INS_FIRST = 3'd1;
  localparam logic [2:0] F_INS_POS   = 3'd2;
  localparam logic [2:0] F_DEL_FIRST = 3'd3;
  localparam logic [2:0] F_DEL_LAST  = 3'd4;
  localparam logic [2:0] F_DEL_POS   = 3'd5;
  localparam logic [2:0] F_DUMP      = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]        func;
    logic [POS_W-1:0]  position;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic               last_result;
  } res_t;

endpackage

[design/pol_ram.sv]
`timescale 1ns / 1ps
module pol_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [pol_pkg::IDX_W-1:0]  waddr,
  input  logic [31:0]                wdata,
  input  logic [pol_pkg::IDX_W-1:0]  raddr,
  output logic [31:0]                rdata
);

  logic [31:0] mem [pol_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/positional_ordered_list.sv]
`timescale 1ns / 1ps
// Bounded ordered list of signed values held in one single-port-read,
// single-port-write memory. A command is taken when start is high and busy
// is low; for a command that shifts entries or dumps the list, busy is then
// high until the command's last result has been registered. Results appear
// on res for exactly one cycle with res_valid high and cannot be held off,
// so the receiver must take every strobe. Commands that need no shifting
// (errors, insert at the tail, delete of the tail, unused codes) complete
// straight from the idle state and never raise busy. Insert and delete at
// a 1-based position move the entries behind it one per cycle through the
// registered memory read port, with the write of the previous entry
// overlapped. A dump gives one result per cycle, the last one marked by
// last_result.
module positional_ordered_list (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pol_pkg::cmd_t   cmd,
  output logic            busy,
  output logic            res_valid,
  output pol_pkg::res_t   res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_DUMP = 3'd4;

  logic [2:0]                state, state_next;
  logic [pol_pkg::IDX_W-1:0] cur, cur_next;
  logic [pol_pkg::IDX_W-1:0] idx, idx_next;
  logic [31:0]               val, val_next;
  logic [pol_pkg::CNT_W-1:0] count, count_next;
  logic                      res_valid_next;
  pol_pkg::res_t             res_next;

  logic                      we;
  logic [pol_pkg::IDX_W-1:0] waddr, raddr;
  logic [31:0]               wdata, rdata;

  logic                      emit, emit_last;
  logic [1:0]                emit_status;
  logic [31:0]               emit_value;

  logic [pol_pkg::CMP_W-1:0] cnt_x, pos_x, ins_pos1, del_pos1;
  logic                      full, empty;
  logic [pol_pkg::IDX_W-1:0] last_idx;

  pol_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy     = (state != S_IDLE);
  assign cnt_x    = pol_pkg::CMP_W'(count);
  assign pos_x    = pol_pkg::CMP_W'(cmd.position);
  assign full     = (count == pol_pkg::CNT_W'(pol_pkg::CAPACITY));
  assign empty    = (count == '0);
  assign last_idx = pol_pkg::IDX_W'(count - 1'b1);

  always_comb begin
    case (cmd.func)
      pol_pkg::F_APPEND:    ins_pos1 = cnt_x + 1'b1;
      pol_pkg::F_INS_FIRST: ins_pos1 = pol_pkg::CMP_W'(1);
      default:              ins_pos1 = pos_x;
    endcase
    case (cmd.func)
      pol_pkg::F_DEL_FIRST: del_pos1 = pol_pkg::CMP_W'(1);
      pol_pkg::F_DEL_LAST:  del_pos1 = cnt_x;
      default:              del_pos1 = pos_x;
    endcase
  end

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    idx_next    = idx;
    val_next    = val;
    count_next  = count;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    emit        = 1'b0;
    emit_last   = 1'b1;
    emit_status = pol_pkg::ST_OK;
    emit_value  = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd.func)
            pol_pkg::F_APPEND, pol_pkg::F_INS_FIRST, pol_pkg::F_INS_POS: begin
              if (cmd.func == pol_pkg::F_INS_POS &&
                  (pos_x == '0 || pos_x > cnt_x + 1'b1)) begin
                emit        = 1'b1;
                emit_status = pol_pkg::ST_BADPOS;
              end else if (full) begin
                emit        = 1'b1;
                emit_status = pol_pkg::ST_FULL;
              end else if (ins_pos1 == cnt_x + 1'b1) begin
                // tail insert needs no shift
                we         = 1'b1;
                waddr      = pol_pkg::IDX_W'(ins_pos1 - 1'b1);
                wdata      = cmd.item_value;
                count_next = count + 1'b1;
                emit       = 1'b1;
              end else begin
                raddr      = last_idx;
                cur_next   = last_idx;
                idx_next   = pol_pkg::IDX_W'(ins_pos1 - 1'b1);
                val_next   = cmd.item_value;
                state_next = S_INS;
              end
            end
            pol_pkg::F_DEL_FIRST, pol_pkg::F_DEL_LAST, pol_pkg::F_DEL_POS: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = pol_pkg::ST_EMPTY;
              end else if (cmd.func == pol_pkg::F_DEL_POS &&
                           (pos_x == '0 || pos_x > cnt_x)) begin
                emit        = 1'b1;
                emit_status = pol_pkg::ST_BADPOS;
              end else if (del_pos1 == cnt_x) begin
                count_next = count - 1'b1;
                emit       = 1'b1;
              end else begin
                // first entry to move down sits just after the deleted one
                raddr      = pol_pkg::IDX_W'(del_pos1);
                cur_next   = pol_pkg::IDX_W'(del_pos1);
                state_next = S_DEL;
              end
            end
            pol_pkg::F_DUMP: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = pol_pkg::ST_EMPTY;
              end else begin
                raddr      = '0;
                cur_next   = '0;
                state_next = S_DUMP;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        we    = 1'b1;
        waddr = cur + 1'b1;
        wdata = rdata;
        if (cur == idx) begin
          state_next = S_PUT;
        end else begin
          raddr    = cur - 1'b1;
          cur_next = cur - 1'b1;
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = idx;
        wdata      = val;
        count_next = count + 1'b1;
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      S_DEL: begin
        we    = 1'b1;
        waddr = cur - 1'b1;
        wdata = rdata;
        if (cur == last_idx) begin
          count_next = count - 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          raddr    = cur + 1'b1;
          cur_next = cur + 1'b1;
        end
      end
      S_DUMP: begin
        emit       = 1'b1;
        emit_value = rdata;
        emit_last  = (cur == last_idx);
        if (cur == last_idx) begin
          state_next = S_IDLE;
        end else begin
          raddr    = cur + 1'b1;
          cur_next = cur + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_valid_next       = emit;
    res_next.status      = emit_status;
    res_next.read_value  = emit_value;
    res_next.entry_count = count_next[4:0];
    res_next.last_result = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      res_valid <= res_valid_next;
    end
    cur <= cur_next;
    idx <= idx_next;
    val <= val_next;
    res <= res_next;
  end

endmodule
